FILE: rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared types and codes for the allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // The link store always covers every 8-bit block index.
    localparam int LINK_DEPTH = 256;
    localparam int IDX_W      = 8;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    localparam logic [1:0] CFG_OBJECT_BYTES = 2'd0;
    localparam logic [1:0] CFG_MAX_OBJECTS  = 2'd1;
    localparam logic [1:0] CFG_POOL_BASE    = 2'd2;

    // One request as it travels from the input to the free list logic.
    typedef struct packed {
        logic        valid;
        logic        req_type;
        logic [15:0] size;
        logic [7:0]  bidx;
    } fbpa_op_t;

    // Outcome of one request as decided by the free list logic.
    typedef struct packed {
        logic       granted;
        logic [7:0] index;
        logic [1:0] status;
    } fbpa_decision_t;

endpackage

FILE: rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fbpa_list.sv
// ----------------------------------------------------------------------------
// Free list and bump index
// Keeps the LIFO free list in the link RAM and decides each request.
// ----------------------------------------------------------------------------
module fbpa_list #(
    parameter int POOL_BLOCKS = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  fbpa_pkg::fbpa_op_t      op,
    input  logic [15:0]             object_bytes,
    input  logic [8:0]              max_objects,
    output fbpa_pkg::fbpa_decision_t dec
);
    import fbpa_pkg::*;

    localparam logic [8:0] LIMIT_CAP =
        (POOL_BLOCKS >= LINK_DEPTH) ? 9'(LINK_DEPTH) : 9'(POOL_BLOCKS);

    logic [7:0] head_reg, head_next;
    logic       nonempty_reg, nonempty_next;
    logic [8:0] fresh_reg, fresh_next;

    logic       wr_en;
    logic [8:0] wr_data;
    logic [8:0] rd_data;
    logic       fresh_ok;

    // The head entry is read when an item is taken, so its successor is
    // ready in the next cycle, when the request is decided.
    fbpa_ram #(
        .WIDTH (9),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (op.bidx),
        .wr_data (wr_data),
        .rd_en   (start),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign fresh_ok = (fresh_reg < max_objects) && (fresh_reg < LIMIT_CAP);

    always_comb begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        fresh_next    = fresh_reg;
        wr_en         = 1'b0;
        wr_data       = {nonempty_reg, head_reg};
        dec.granted   = 1'b0;
        dec.index     = '0;
        dec.status    = ST_OK;
        if (op.valid) begin
            if (op.req_type == REQ_FREE) begin
                wr_en         = 1'b1;
                head_next     = op.bidx;
                nonempty_next = 1'b1;
                dec.granted   = 1'b1;
            end else if (op.size > object_bytes) begin
                dec.status = ST_TOO_LARGE;
            end else if (nonempty_reg) begin
                dec.granted   = 1'b1;
                dec.index     = head_reg;
                nonempty_next = rd_data[8];
                head_next     = rd_data[7:0];
            end else if (fresh_ok) begin
                dec.granted = 1'b1;
                dec.index   = fresh_reg[7:0];
                fresh_next  = fresh_reg + 9'd1;
            end else begin
                dec.status = ST_EXHAUSTED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= '0;
        end else begin
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            fresh_reg    <= fresh_next;
        end
    end

endmodule

FILE: rtl/fbpa_addr.sv
// ----------------------------------------------------------------------------
// Block address unit
// Multiplies the block index by the stride, then adds the pool base.
// ----------------------------------------------------------------------------
module fbpa_addr #(
    parameter int POINTER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic        hit,
    input  logic [7:0]  index,
    input  logic [15:0] object_bytes,
    input  logic [31:0] pool_base,
    output logic [31:0] addr
);

    localparam logic [15:0] PTR_MIN = 16'(POINTER_BYTES);

    logic [15:0] stride;
    logic [23:0] product_reg;
    logic        hit_reg;

    assign stride = (object_bytes < PTR_MIN) ? PTR_MIN : object_bytes;

    always_ff @(posedge aclk) begin
        if (load) begin
            product_reg <= {16'd0, index} * {8'd0, stride};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (load) begin
            hit_reg <= hit;
        end
    end

    // Addresses wrap modulo 2^32; a request without a block returns zero.
    assign addr = hit_reg ? (pool_base + {8'd0, product_reg}) : 32'd0;

endmodule

FILE: rtl/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Serves allocate and free requests on a pool of fixed-size blocks.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Direction  Moves
//  ------    ----------------------------  ---------  ------------------------
//  request   s_valid/s_ready, s_*          in         one allocate or free item
//  result    m_valid/m_ready, m_*          out        one result item per item
//  config    cfg_we, cfg_addr, cfg_wdata   in         register writes, no wait
//
// From acceptance to a valid result an item goes through the link RAM read of
// the list head, then the decision, which updates the list and counters while
// the index times stride product is registered, and then the addition of the
// pool base into the output register. A new item is accepted once the
// previous one has reached the output register, even while that result still
// waits for m_ready; a stalled output holds the block in its last step.
// Reset clears the list, bump index and counters at once; the link RAM needs
// no clearing, as an entry is always written before its contents are used.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
    parameter int POOL_BLOCKS   = 256,
    parameter int POINTER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_request_size,
    input  logic [7:0]  s_block_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_granted,
    output logic [7:0]  m_given_index,
    output logic [31:0] m_block_address,
    output logic [1:0]  m_status,
    output logic [8:0]  m_in_use_count,
    output logic [31:0] m_allocation_count,
    output logic [31:0] m_free_count
);
    import fbpa_pkg::*;

    // Sequencer states: waiting for an item, deciding it, writing the result.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ADDR = 2'd2;

    logic [1:0] state_reg, state_next;

    // Configuration registers.
    logic [15:0] object_bytes_reg;
    logic [8:0]  max_objects_reg;
    logic [31:0] pool_base_reg;

    // The accepted request, held while it is worked on.
    logic        req_type_reg;
    logic [15:0] req_size_reg;
    logic [7:0]  req_bidx_reg;

    // Counters.
    logic [8:0]  in_use_reg, in_use_next;
    logic [31:0] alloc_total_reg, alloc_total_next;
    logic [31:0] free_total_reg, free_total_next;

    // The decision, held for the address step.
    fbpa_decision_t dec, dec_reg;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic        granted_reg;
    logic [7:0]  given_index_reg;
    logic [31:0] block_address_reg;
    logic [1:0]  status_reg;
    logic [8:0]  in_use_out_reg;
    logic [31:0] alloc_out_reg;
    logic [31:0] free_out_reg;

    logic           accept;
    logic           exec;
    logic           out_load;
    fbpa_op_t       op;
    logic [31:0]    addr;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign exec     = (state_reg == S_EXEC);
    // The result moves into the output register once any earlier one is gone.
    assign out_load = (state_reg == S_ADDR) && (!m_valid_reg || m_ready);

    assign op.valid    = exec;
    assign op.req_type = req_type_reg;
    assign op.size     = req_size_reg;
    assign op.bidx     = req_bidx_reg;

    fbpa_list #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_list (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (accept),
        .op           (op),
        .object_bytes (object_bytes_reg),
        .max_objects  (max_objects_reg),
        .dec          (dec)
    );

    fbpa_addr #(
        .POINTER_BYTES (POINTER_BYTES)
    ) u_addr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (exec),
        .hit          (dec.granted && (req_type_reg == REQ_ALLOC)),
        .index        (dec.index),
        .object_bytes (object_bytes_reg),
        .pool_base    (pool_base_reg),
        .addr         (addr)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_ADDR;
            end
            S_ADDR: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Counters move only on a granted request; the use count saturates at
    // both ends.
    always_comb begin
        in_use_next      = in_use_reg;
        alloc_total_next = alloc_total_reg;
        free_total_next  = free_total_reg;
        if (exec && dec.granted) begin
            if (req_type_reg == REQ_FREE) begin
                free_total_next = free_total_reg + 32'd1;
                if (in_use_reg != 9'd0) begin
                    in_use_next = in_use_reg - 9'd1;
                end
            end else begin
                alloc_total_next = alloc_total_reg + 32'd1;
                if (in_use_reg != 9'h1FF) begin
                    in_use_next = in_use_reg + 9'd1;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            in_use_reg       <= '0;
            alloc_total_reg  <= '0;
            free_total_reg   <= '0;
            object_bytes_reg <= 16'd8;
            max_objects_reg  <= 9'd256;
            pool_base_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            in_use_reg      <= in_use_next;
            alloc_total_reg <= alloc_total_next;
            free_total_reg  <= free_total_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_OBJECT_BYTES: object_bytes_reg <= cfg_wdata[15:0];
                    CFG_MAX_OBJECTS:  max_objects_reg  <= cfg_wdata[8:0];
                    CFG_POOL_BASE:    pool_base_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= s_req_type;
            req_size_reg <= s_request_size;
            req_bidx_reg <= s_block_index;
        end
        if (exec) begin
            dec_reg <= dec;
        end
        if (out_load) begin
            granted_reg       <= dec_reg.granted;
            given_index_reg   <= dec_reg.index;
            block_address_reg <= addr;
            status_reg        <= dec_reg.status;
            in_use_out_reg    <= in_use_reg;
            alloc_out_reg     <= alloc_total_reg;
            free_out_reg      <= free_total_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_granted          = granted_reg;
    assign m_given_index      = given_index_reg;
    assign m_block_address    = block_address_reg;
    assign m_status           = status_reg;
    assign m_in_use_count     = in_use_out_reg;
    assign m_allocation_count = alloc_out_reg;
    assign m_free_count       = free_out_reg;

endmodule
